[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the run state detector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define CRSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crsd assertion failed");

// Clocked check that also holds across reset.
`define CRSD_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("crsd reset assertion failed");

`endif

[rtl/crsd_pkg.sv]
// ----------------------------------------------------------------------------
// crsd_pkg
// Types, constants and helpers for the channel run state detector.
// ----------------------------------------------------------------------------
package crsd_pkg;

  localparam int NUM_CHANNELS_DEF = 19;
  localparam logic [3:0] CONFIRM_RESET = 4'd3;
  localparam logic [3:0] AGREE_MAX = 4'd15;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_START    = 2'd1,
    EV_STOP     = 2'd2,
    EV_DECREASE = 2'd3
  } ev_t;

  typedef struct packed {
    logic [4:0]         channel;
    logic signed [23:0] seconds_count;
    logic [16:0]        time_of_day;
    logic               session_start;
    logic               day_rollover;
  } in_t;

  typedef struct packed {
    logic [4:0]  out_channel;
    logic [1:0]  event_res;
    logic [16:0] event_time;
    logic        running;
    logic [31:0] today_seconds;
  } out_t;

  typedef struct packed {
    logic signed [23:0] last_count;
    logic               run_flag;
    logic [3:0]         agree_count;
    logic [31:0]        day_total;
  } state_t;

  localparam int STATE_W = $bits(state_t);

  // total + delta, clamped to 0 .. 2^32-1
  function automatic logic [31:0] sat_add(input logic [31:0] total,
                                          input logic signed [23:0] delta);
    logic [33:0] s;
    s = {2'b00, total} + {{10{delta[23]}}, delta};
    if (s[33]) begin
      sat_add = 32'd0;
    end else if (s[32]) begin
      sat_add = 32'hFFFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

[rtl/crsd_ram.sv]
// ----------------------------------------------------------------------------
// crsd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module crsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/channel_run_state_detector_unit.sv]
// ----------------------------------------------------------------------------
// channel_run_state_detector_unit
// Per-channel run/stop detector with confirmation hysteresis and day totals.
// ----------------------------------------------------------------------------
// Pipeline: the input transfer loads stage 1 and the registered state RAM
//   read; the output register then loads from stage 1 when the output is free.
// Throughput: one item per cycle unless the output stalls; per-channel state
//   RMW in a registered-read RAM, bypassing the previous write to the channel.
// Reset: synchronous; clears confirm to 3, per-channel valid bits (state
//   reads as zero) and the pipeline. No clearing pass.
module channel_run_state_detector_unit #(
  parameter int NUM_CHANNELS = crsd_pkg::NUM_CHANNELS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  crsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output crsd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_data
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [3:0]                   confirm;
  logic                         s1_valid;
  crsd_pkg::in_t                s1_data;
  logic                         s1_fwd;
  crsd_pkg::state_t             fwd_state;
  logic [NUM_CHANNELS-1:0]      vld;

  logic                         s1_adv;
  logic                         s1_fire;
  logic                         in_fire;
  logic                         in_range;
  logic                         we;
  logic [AW-1:0]                s1_addr;
  logic [AW-1:0]                in_addr;
  logic [crsd_pkg::STATE_W-1:0] rd_data;
  crsd_pkg::state_t             cur;
  crsd_pkg::state_t             st_next;
  crsd_pkg::out_t               res_next;

  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign in_range = 32'(s1_data.channel) < 32'(NUM_CHANNELS);
  assign we       = s1_fire && in_range;
  assign s1_addr  = AW'(s1_data.channel);
  assign in_addr  = AW'(in_data.channel);

  crsd_ram #(
    .WIDTH (crsd_pkg::STATE_W),
    .DEPTH (NUM_CHANNELS),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (st_next),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  always_comb begin
    if (s1_fwd) begin
      cur = fwd_state;
    end else if (in_range && vld[s1_addr]) begin
      cur = crsd_pkg::state_t'(rd_data);
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    logic [3:0]     agree_inc;
    crsd_pkg::ev_t  ev;
    st_next = cur;
    ev      = crsd_pkg::EV_NONE;
    if (s1_data.session_start) begin
      st_next.day_total  = crsd_pkg::sat_add(cur.day_total, cur.last_count);
      st_next.last_count = '0;
      if (s1_data.day_rollover) begin
        st_next.day_total = '0;
      end
    end
    agree_inc = (cur.agree_count == crsd_pkg::AGREE_MAX) ? crsd_pkg::AGREE_MAX
                                                         : cur.agree_count + 4'd1;
    if (s1_data.seconds_count > st_next.last_count) begin
      if (!cur.run_flag) begin
        if (agree_inc >= confirm) begin
          st_next.agree_count = '0;
          st_next.run_flag    = 1'b1;
          ev                  = crsd_pkg::EV_START;
        end else begin
          st_next.agree_count = agree_inc;
        end
      end else begin
        st_next.agree_count = '0;
      end
    end else if (s1_data.seconds_count == st_next.last_count) begin
      if (cur.run_flag) begin
        if (agree_inc >= confirm) begin
          st_next.agree_count = '0;
          st_next.run_flag    = 1'b0;
          ev                  = crsd_pkg::EV_STOP;
        end else begin
          st_next.agree_count = agree_inc;
        end
      end else begin
        st_next.agree_count = '0;
      end
    end else begin
      ev = crsd_pkg::EV_DECREASE;
    end
    st_next.last_count = s1_data.seconds_count;

    res_next.out_channel = s1_data.channel;
    if (in_range) begin
      res_next.event_res     = ev;
      res_next.event_time    = (ev != crsd_pkg::EV_NONE) ? s1_data.time_of_day : '0;
      res_next.running       = st_next.run_flag;
      res_next.today_seconds = crsd_pkg::sat_add(st_next.day_total,
                                                 s1_data.seconds_count);
    end else begin
      res_next.event_res     = crsd_pkg::EV_NONE;
      res_next.event_time    = '0;
      res_next.running       = 1'b0;
      res_next.today_seconds = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm   <= crsd_pkg::CONFIRM_RESET;
      s1_valid  <= 1'b0;
      s1_fwd    <= 1'b0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        confirm <= cfg_data;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
        s1_fwd   <= we && (s1_data.channel == in_data.channel);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (we) begin
        vld[s1_addr] <= 1'b1;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data <= in_data;
    end
    if (we) begin
      fwd_state <= st_next;
    end
    if (s1_fire) begin
      out_data <= res_next;
    end
  end

endmodule

[rtl/crsd_checker.sv]
// ----------------------------------------------------------------------------
// crsd_checker
// Port-level checks on results of the channel run state detector.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crsd_checker #(
  parameter int NUM_CHANNELS = crsd_pkg::NUM_CHANNELS_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input crsd_pkg::out_t out_data
);

  `CRSD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `CRSD_ASSERT(a_time_zero, clk, rst, out_valid && out_data.event_res == crsd_pkg::EV_NONE |-> out_data.event_time == '0)
  `CRSD_ASSERT(a_bad_channel, clk, rst, out_valid && 32'(out_data.out_channel) >= 32'(NUM_CHANNELS) |-> out_data.event_res == crsd_pkg::EV_NONE && !out_data.running && out_data.today_seconds == '0)
  `CRSD_ASSERT(a_event_flag, clk, rst, out_valid && (out_data.event_res == crsd_pkg::EV_START || out_data.event_res == crsd_pkg::EV_STOP) |-> out_data.running == (out_data.event_res == crsd_pkg::EV_START))
  `CRSD_ASSERT_RST(a_reset_idle, clk, rst |=> !out_valid)

endmodule

bind channel_run_state_detector_unit crsd_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_crsd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
